// ===== sv/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared constants, round functions and control structs of the hash engine
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned ROUNDS = 64;
    localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;

    localparam logic [31:0] K_TAB [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic        load_byte;
        logic        pad;
        logic        len_only;
        logic        shift;
        logic [7:0]  data;
        logic [5:0]  pos;
        logic [63:0] bit_len;
    } t_sched_ctl;

    typedef struct packed {
        logic       init;
        logic       rnd;
        logic       fin;
        logic       iv;
        logic [5:0] rnd_idx;
    } t_core_ctl;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ===== sv/sha256_hash_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit
// SHA-256 over a byte stream, digest words out on a stream channel
// ----------------------------------------------------------------------------
// input channel: one item per message byte (tdata), tuser flags a byte
// present, tlast ends the message; an item with no byte and no tlast is a no-op
// output channel: eight digest words per message, most significant first,
// tuser holds the word index and tlast marks the eighth word
// a byte item is taken while the engine is idle; every 64th byte adds a compression
// (a load of the working state, 64 rounds on the shared round unit, one state update)
// a last item adds a padding step and a compression, and a length step and a
// second compression when eight or fewer bytes of the block remain; then the digest goes out
// throughput is set by the round unit, which does one round per cycle
// the input is not ready while padding, while a block compresses or the digest goes out
// when the receiver stalls the digest output waits word by word; the last
// word sits in the output register while new input is already taken
// reset loads the initial hash vector and clears the byte count
// ----------------------------------------------------------------------------
module sha256_hash_engine_unit import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // msg_byte
    input  logic        i_s_tuser,  // byte_present
    input  logic        i_s_tlast,  // last_item
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // digest_word
    output logic [2:0]  o_m_tuser,  // word_index
    output logic        o_m_tlast   // last_word
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PAD  = 7'b0000010,
        ST_LEN  = 7'b0000100,
        ST_PRE  = 7'b0001000,
        ST_RUN  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        AF_IDLE,
        AF_PAD,
        AF_LEN,
        AF_OUT
    } t_after;

    t_state      r_state, n_state;
    t_after      r_after, n_after;
    logic [5:0]  r_rnd, n_rnd;
    logic [2:0]  r_widx, n_widx;
    logic [60:0] r_count, n_count;
    logic        r_ovalid;
    logic [31:0] r_odata;
    logic [2:0]  r_ouser;
    logic        r_olast;
    logic        in_acc;
    logic        out_load;
    logic [5:0]  pos;
    logic [31:0] w0, w1, rd_word;
    t_sched_ctl  sched_ctl;
    t_core_ctl   core_ctl;

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign pos        = r_count[5:0];

    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        n_rnd    = r_rnd;
        n_widx   = r_widx;
        n_count  = r_count;
        out_load = 1'b0;

        sched_ctl           = '0;
        sched_ctl.data      = i_s_tdata;
        sched_ctl.pos       = pos;
        sched_ctl.bit_len   = {r_count, 3'd0};
        core_ctl            = '0;
        core_ctl.rnd_idx    = r_rnd;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_s_tuser) begin
                        sched_ctl.load_byte = 1'b1;
                        n_count = r_count + 61'd1;
                        if (pos == 6'd63) begin
                            n_state = ST_PRE;
                            n_after = i_s_tlast ? AF_PAD : AF_IDLE;
                        end else if (i_s_tlast) begin
                            n_state = ST_PAD;
                        end
                    end else if (i_s_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                sched_ctl.pad = 1'b1;
                n_after = (pos[5:3] == 3'b111) ? AF_LEN : AF_OUT;
                n_state = ST_PRE;
            end
            ST_LEN: begin
                sched_ctl.len_only = 1'b1;
                n_after = AF_OUT;
                n_state = ST_PRE;
            end
            ST_PRE: begin
                core_ctl.init = 1'b1;
                n_rnd   = '0;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                core_ctl.rnd    = 1'b1;
                sched_ctl.shift = 1'b1;
                n_rnd = 6'(r_rnd + 6'd1);
                if (r_rnd == LAST_ROUND) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                core_ctl.fin = 1'b1;
                unique case (r_after)
                    AF_IDLE: n_state = ST_IDLE;
                    AF_PAD:  n_state = ST_PAD;
                    AF_LEN:  n_state = ST_LEN;
                    AF_OUT: begin
                        n_state = ST_OUT;
                        n_widx  = '0;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    out_load = 1'b1;
                    if (r_widx == LAST_WORD_IDX) begin
                        core_ctl.iv = 1'b1;
                        n_count = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_widx = 3'(r_widx + 3'd1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_after  <= AF_IDLE;
            r_rnd    <= '0;
            r_widx   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_rnd   <= n_rnd;
            r_widx  <= n_widx;
            r_count <= n_count;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_odata <= rd_word;
            r_ouser <= r_widx;
            r_olast <= (r_widx == LAST_WORD_IDX);
        end
    end

    sha_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w0  (w0),
        .o_w1  (w1)
    );

    sha_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (core_ctl),
        .i_w0      (w0),
        .i_w1      (w1),
        .i_rd_idx  (r_widx),
        .o_rd_word (rd_word)
    );

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

    a_last_matches_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser == LAST_WORD_IDX)))
        else $error("tlast does not match the word index");

    a_words_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast)
            |=> (o_m_tvalid && o_m_tuser == 3'($past(o_m_tuser) + 3'd1)))
        else $error("digest words out of order");

    a_rounds_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_rnd == LAST_ROUND) |=> (r_state == ST_FIN))
        else $error("compression did not end after the last round");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_load && r_widx == LAST_WORD_IDX)
            |=> (r_count == '0 && r_state == ST_IDLE))
        else $error("byte count not cleared after the digest");

endmodule

// ===== sv/sha_sched.sv =====
// ----------------------------------------------------------------------------
// sha_sched
// Message block window: byte packing, padding and sliding schedule expansion
// ----------------------------------------------------------------------------
module sha_sched import sha_pkg::*; (
    input  logic        i_clk,
    input  t_sched_ctl  i_ctl,
    output logic [31:0] o_w0,
    output logic [31:0] o_w1
);

    logic [31:0] r_w [16];
    logic [31:0] r_acc;
    logic [31:0] n_acc;
    logic [31:0] n_new;
    logic [31:0] pad_word;
    logic [3:0]  idx;
    logic [1:0]  lane;
    logic        len_fits;

    always_comb begin
        idx      = i_ctl.pos[5:2];
        lane     = i_ctl.pos[1:0];
        len_fits = (i_ctl.pos[5:3] != 3'b111);
        if (lane == 2'd0) begin
            n_acc    = {i_ctl.data, 24'd0};
            pad_word = {PAD_BYTE, 24'd0};
        end else begin
            n_acc    = r_acc | ({i_ctl.data, 24'd0} >> {lane, 3'd0});
            pad_word = r_acc | ({PAD_BYTE, 24'd0} >> {lane, 3'd0});
        end
        n_new = r_w[0] + sig0(r_w[1]) + r_w[9] + sig1(r_w[14]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_byte) begin
            r_acc    <= n_acc;
            r_w[idx] <= n_acc;
        end else if (i_ctl.pad) begin
            for (int i = 0; i < 16; i++) begin
                if (4'(i) > idx && (i < 14 || !len_fits)) begin
                    r_w[i] <= '0;
                end
            end
            r_w[idx] <= pad_word;
            if (len_fits) begin
                r_w[14] <= i_ctl.bit_len[63:32];
                r_w[15] <= i_ctl.bit_len[31:0];
            end
        end else if (i_ctl.len_only) begin
            for (int i = 0; i < 14; i++) begin
                r_w[i] <= '0;
            end
            r_w[14] <= i_ctl.bit_len[63:32];
            r_w[15] <= i_ctl.bit_len[31:0];
        end else if (i_ctl.shift) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= n_new;
        end
    end

    assign o_w0 = r_w[0];
    assign o_w1 = r_w[1];

endmodule

// ===== sv/sha_core.sv =====
// ----------------------------------------------------------------------------
// sha_core
// Hash state and the shared round unit, one compression round per cycle
// ----------------------------------------------------------------------------
module sha_core import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_core_ctl   i_ctl,
    input  logic [31:0] i_w0,
    input  logic [31:0] i_w1,
    input  logic [2:0]  i_rd_idx,
    output logic [31:0] o_rd_word
);

    logic [31:0] r_hash [8];
    logic [31:0] r_v [8];
    logic [31:0] r_hkw;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [5:0]  k_idx;

    // h + k + w of the coming round is summed in the cycle before, into a register
    always_comb begin
        t1    = r_hkw + big1(r_v[4]) + ch(r_v[4], r_v[5], r_v[6]);
        t2    = big0(r_v[0]) + maj(r_v[0], r_v[1], r_v[2]);
        k_idx = 6'(i_ctl.rnd_idx + 6'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.iv) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= IV_TAB[i];
            end
        end else if (i_ctl.fin) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= r_hash[i] + r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_hash[i];
            end
            r_hkw <= r_hash[7] + K_TAB[0] + i_w0;
        end else if (i_ctl.rnd) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            r_hkw  <= r_v[6] + K_TAB[k_idx] + i_w1;
        end
    end

    assign o_rd_word = r_hash[i_rd_idx];

endmodule

// ===== tb/tb_sha256_hash_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_hash_engine_unit
// Self-checking bench for the byte-stream SHA-256 engine. Messages are sent
// as byte items; a digest model in the bench hashes every accepted item and
// queues the eight digest words each message end must produce. Every word
// that leaves the engine is compared against the oldest queued word. A short
// table of hand-picked items comes first. Random messages of mixed lengths
// follow, covering block and padding boundaries, with no-op items, split
// message ends and random stalls on both channels mixed in.
// ----------------------------------------------------------------------------
module tb_sha256_hash_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import sha_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int RAND_ITEMS   = 120;
    localparam int MIN_LONG     = 1;
    localparam int MAX_PRINTS   = 50;

    typedef struct packed {
        logic [7:0] b;
        logic       p;
        logic       l;
    } t_byte_item;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } t_digest_word;

    localparam int N_DIRECTED = 18;
    localparam t_byte_item DIRECTED [N_DIRECTED] = '{
        {8'h00, 1'b0, 1'b1},  // empty message right after reset
        {8'ha5, 1'b0, 1'b0},  // no-op item
        {8'h61, 1'b1, 1'b0},
        {8'h62, 1'b1, 1'b0},
        {8'h63, 1'b1, 1'b1},  // end carried on the last byte
        {8'h00, 1'b1, 1'b1},
        {8'hff, 1'b1, 1'b1},
        {8'hff, 1'b1, 1'b0},
        {8'h00, 1'b0, 1'b0},
        {8'h80, 1'b1, 1'b0},
        {8'h7f, 1'b1, 1'b0},
        {8'h3c, 1'b0, 1'b1},  // end with no byte after some bytes
        {8'h5a, 1'b0, 1'b0},
        {8'hc3, 1'b0, 1'b1},  // second empty message
        {8'h01, 1'b1, 1'b0},
        {8'hfe, 1'b1, 1'b0},
        {8'haa, 1'b1, 1'b0},
        {8'h55, 1'b1, 1'b1}
    };

    localparam int LONG_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;  // msg_byte
    logic        i_s_tuser  = 1'b0;   // byte_present
    logic        i_s_tlast  = 1'b0;   // last_item
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;           // digest_word
    logic [2:0]  o_m_tuser;           // word_index
    logic        o_m_tlast;           // last_word

    sha256_hash_engine_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // digest model state
    logic [31:0]  hash_words [8];
    logic [31:0]  block_buf [16];
    logic [60:0]  msg_len;
    t_digest_word digest_q [$];

    int err_cnt      = 0;
    int cycle_cnt    = 0;
    int sent_items   = 0;
    bit no_idle      = 1'b0;
    bit hold_off_req = 1'b0;

    task automatic report_mismatch(input string what);
        if (err_cnt < MAX_PRINTS)
            $display("%0t mismatch: %s", $realtime, what);
        err_cnt++;
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rr(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = block_buf[i];
        for (int i = 16; i < 64; i++) begin
            s0 = rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        {a, b, c, d} = {hash_words[0], hash_words[1], hash_words[2], hash_words[3]};
        {e, f, g, h} = {hash_words[4], hash_words[5], hash_words[6], hash_words[7]};
        for (int i = 0; i < 64; i++) begin
            s1 = rr(e, 6) ^ rr(e, 11) ^ rr(e, 25);
            t1 = h + s1 + ((e & f) ^ (~e & g)) + K_TAB[i] + w[i];
            s0 = rr(a, 2) ^ rr(a, 13) ^ rr(a, 22);
            t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
            h = g;
            g = f;
            f = e;
            e = d + t1;
            d = c;
            c = b;
            b = a;
            a = t1 + t2;
        end
        hash_words[0] += a;
        hash_words[1] += b;
        hash_words[2] += c;
        hash_words[3] += d;
        hash_words[4] += e;
        hash_words[5] += f;
        hash_words[6] += g;
        hash_words[7] += h;
    endfunction

    // big-endian byte lane; lane 0 clears the rest of the word
    function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
        if (pos[1:0] == 2'd0)
            block_buf[pos[5:2]] = {b, 24'h000000};
        else
            block_buf[pos[5:2]][8 * (3 - int'(pos[1:0])) +: 8] = b;
    endfunction

    function automatic void hash_item(input t_byte_item it);
        logic [5:0]   pos;
        logic [63:0]  bit_len;
        t_digest_word dw;
        if (it.p) begin
            pos = msg_len[5:0];
            place_byte(pos, it.b);
            msg_len = msg_len + 61'd1;
            if (pos == 6'd63)
                compress_block();
        end
        if (!it.l)
            return;
        pos = msg_len[5:0];
        place_byte(pos, PAD_BYTE);
        for (int i = int'(pos[5:2]) + 1; i < 16; i++)
            block_buf[i] = '0;
        if (pos >= 6'd56) begin
            compress_block();
            for (int i = 0; i < 16; i++)
                block_buf[i] = '0;
        end
        bit_len = {msg_len, 3'b000};
        block_buf[14] = bit_len[63:32];
        block_buf[15] = bit_len[31:0];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            dw.word = hash_words[i];
            dw.idx  = 3'(i);
            dw.fin  = (3'(i) == LAST_WORD_IDX);
            digest_q.push_back(dw);
        end
        hash_words = IV_TAB;
        msg_len = '0;
    endfunction

    task automatic send_item(input t_byte_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= it.b;
        i_s_tuser  <= it.p;
        i_s_tlast  <= it.l;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        hash_item(it);
        if (it.p || it.l)
            sent_items++;
    endtask

    task automatic send_message(input int len);
        t_byte_item it;
        bit         split;
        split = (len > 0) && ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0)
            no_idle = !no_idle;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                it = {8'($urandom), 1'b0, 1'b0};
                send_item(it);
            end
            it = {8'($urandom), 1'b1, (k == len - 1) && !split};
            send_item(it);
        end
        if (len == 0 || split) begin
            it = {8'($urandom), 1'b0, 1'b1};
            send_item(it);
        end
    endtask

    task automatic wait_drained();
        while (digest_q.size() != 0)
            @(posedge i_clk);
    endtask

    // receiver: random stalls, one long hold-off, word checks
    initial begin
        int           stall_left;
        t_digest_word got;
        t_digest_word want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid === 1'b1 && i_m_tready) begin
                got = {o_m_tdata, o_m_tuser, o_m_tlast};
                if (digest_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected digest word %h idx %0d",
                                              got.word, got.idx));
                end else begin
                    want = digest_q.pop_front();
                    if (got.word !== want.word)
                        report_mismatch($sformatf("word idx %0d: got %h want %h",
                                                  want.idx, got.word, want.word));
                    if (got.idx !== want.idx)
                        report_mismatch($sformatf("index: got %0d want %0d",
                                                  got.idx, want.idx));
                    if (got.fin !== want.fin)
                        report_mismatch($sformatf("last flag idx %0d: got %b want %b",
                                                  want.idx, got.fin, want.fin));
                end
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (no_idle || $urandom_range(0, 3) != 0) begin
                i_m_tready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                i_m_tready <= (stall_left == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int len;
        int long_msgs;
        int msg_cnt;
        hash_words = IV_TAB;
        for (int i = 0; i < 16; i++)
            block_buf[i] = '0;
        msg_len = '0;
        long_msgs = 0;
        msg_cnt = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(DIRECTED[i]);
        i_s_tvalid <= 1'b0;
        wait_drained();

        hold_off_req = 1'b1;
        sent_items = 0;
        while (sent_items < RAND_ITEMS || long_msgs < MIN_LONG) begin
            if ($urandom_range(0, 3) == 0) begin
                len = LONG_LENS[$urandom_range(0, 7)];
                long_msgs++;
            end else begin
                len = $urandom_range(0, 12);
            end
            send_message(len);
            msg_cnt++;
            if (msg_cnt == 6) begin
                i_s_tvalid <= 1'b0;
                wait_drained();
            end
        end
        i_s_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sha_pkg.sv
sv/sha_sched.sv
sv/sha_core.sv
sv/sha256_hash_engine_unit.sv
tb/tb_sha256_hash_engine_unit.sv
